>>> src/sync_escaped_frame_receiver_defines.svh
// Assertion macros shared by the frame receiver checkers.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef SYNC_ESCAPED_FRAME_RECEIVER_DEFINES_SVH
`define SYNC_ESCAPED_FRAME_RECEIVER_DEFINES_SVH

// check that holds outside reset
`define SEFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also covers the reset cycles
`define SEFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/sefr_pkg.sv
// Types, phase codes and constants of the sync escaped frame receiver.
// No dependencies.
package sefr_pkg;

  localparam int unsigned MAX_PAYLOAD = 255;

  localparam logic [7:0] SYNC_RESET = 8'd126;

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  typedef struct packed {
    logic [1:0] phase;
    logic       esc_pending;
    logic [7:0] exp_len;
    logic [7:0] rcv_cnt;
  } frame_state_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] payload_byte;
    logic       first_of_frame;
    logic       last_of_frame;
    logic       frame_aborted;
  } frame_result_t;

endpackage

>>> src/sefr_decode.sv
// Next-state and result logic for one received byte.
// Depends on sefr_pkg.
module sefr_decode (
  input  logic [7:0]             rx_byte,
  input  logic [7:0]             sync_value,
  input  sefr_pkg::frame_state_t cur,
  output sefr_pkg::frame_state_t nxt,
  output sefr_pkg::frame_result_t res
);

  logic       hit;
  logic       use_byte;
  logic       len_ok;

  assign hit    = (rx_byte == sync_value);
  assign len_ok = (rx_byte != 8'd0) &&
                  ({24'd0, rx_byte} <= 32'(sefr_pkg::MAX_PAYLOAD));

  always_comb begin
    nxt      = cur;
    res      = '0;
    use_byte = 1'b0;
    if (hit) begin
      if (cur.phase == sefr_pkg::PH_HUNT) begin
        nxt.phase       = sefr_pkg::PH_LEN;
        nxt.esc_pending = 1'b0;
      end else if (!cur.esc_pending) begin
        nxt.esc_pending = 1'b1;
      end else begin
        nxt.esc_pending = 1'b0;
        use_byte        = 1'b1;
      end
    end else if (cur.esc_pending) begin
      // resync: byte becomes the new length
      nxt.esc_pending = 1'b0;
      nxt.exp_len     = rx_byte;
      nxt.rcv_cnt     = 8'd0;
      nxt.phase       = len_ok ? sefr_pkg::PH_DATA : sefr_pkg::PH_HUNT;
      if (cur.phase == sefr_pkg::PH_DATA) begin
        res.emit          = 1'b1;
        res.frame_aborted = 1'b1;
      end
    end else begin
      use_byte = 1'b1;
    end

    if (use_byte) begin
      priority if (cur.phase == sefr_pkg::PH_LEN) begin
        nxt.exp_len = rx_byte;
        nxt.rcv_cnt = 8'd0;
        nxt.phase   = len_ok ? sefr_pkg::PH_DATA : sefr_pkg::PH_HUNT;
      end else if (cur.phase == sefr_pkg::PH_DATA) begin
        nxt.rcv_cnt        = cur.rcv_cnt + 8'd1;
        res.emit           = 1'b1;
        res.payload_byte   = rx_byte;
        res.first_of_frame = (cur.rcv_cnt == 8'd0);
        res.last_of_frame  = (nxt.rcv_cnt == cur.exp_len);
        if (res.last_of_frame) begin
          nxt.phase = sefr_pkg::PH_HUNT;
        end
      end else begin
        nxt.phase = sefr_pkg::PH_HUNT;
      end
    end
  end

endmodule

>>> src/sync_escaped_frame_receiver.sv
// Sync escaped frame receiver: top level with input, state and result registers.
// Depends on sefr_pkg and sefr_decode.
//
// Takes one received byte per transfer and deframes it: hunts for the sync
// byte, takes the next byte as payload length, then passes each payload byte
// out with first and last markers. A doubled sync byte inside a frame is one
// literal data byte; a sync byte followed by another value restarts the frame,
// reports an open frame as aborted and takes that value as the new length.
// Throughput is one byte per clock unless a stalled output holds the result.
// The byte is registered, decoded against the framing state, and the result
// is registered. The input register also absorbs one byte while a result
// waits on a stalled output. sync_value resets to 126; the user must write it
// through cfg_wr_en/cfg_wr_data while the block is idle; the block does not enforce this.
module sync_escaped_frame_receiver (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_payload_byte,
  output logic       out_first_of_frame,
  output logic       out_last_of_frame,
  output logic       out_frame_aborted
);

  logic [7:0]              sync_r;
  logic                    in_vld_r;
  logic [7:0]              in_byte_r;
  sefr_pkg::frame_state_t  st_r;
  sefr_pkg::frame_state_t  st_nxt;
  sefr_pkg::frame_result_t res_nxt;
  logic                    out_vld_r;
  logic [7:0]              out_byte_r;
  logic                    out_first_r;
  logic                    out_last_r;
  logic                    out_abort_r;
  logic                    advance;

  assign advance  = !(out_vld_r && out_stall);
  assign in_stall = in_vld_r && !advance;

  sefr_decode u_decode (
    .rx_byte    (in_byte_r),
    .sync_value (sync_r),
    .cur        (st_r),
    .nxt        (st_nxt),
    .res        (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= sefr_pkg::SYNC_RESET;
    end else if (cfg_wr_en) begin
      sync_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{phase: sefr_pkg::PH_HUNT, esc_pending: 1'b0,
                exp_len: 8'd0, rcv_cnt: 8'd0};
    end else if (advance && in_vld_r) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r && res_nxt.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte_r  <= res_nxt.payload_byte;
      out_first_r <= res_nxt.first_of_frame;
      out_last_r  <= res_nxt.last_of_frame;
      out_abort_r <= res_nxt.frame_aborted;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_payload_byte   = out_byte_r;
  assign out_first_of_frame = out_first_r;
  assign out_last_of_frame  = out_last_r;
  assign out_frame_aborted  = out_abort_r;

endmodule

>>> src/sefr_checker.sv
// Port-level checks for the sync escaped frame receiver, bound to the top level.
// Depends on sync_escaped_frame_receiver_defines.svh.
`include "sync_escaped_frame_receiver_defines.svh"

module sefr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_payload_byte,
  input logic       out_first_of_frame,
  input logic       out_last_of_frame,
  input logic       out_frame_aborted
);

  `SEFR_ASSERT_ALWAYS(a_rst_clears_out, !rst_n |=> !out_valid, "out_valid after reset")

  `SEFR_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_payload_byte) && $stable(out_frame_aborted), "stalled result changed")

  `SEFR_ASSERT(a_abort_clean, out_valid && out_frame_aborted |-> out_payload_byte == 8'd0 && !out_first_of_frame && !out_last_of_frame, "abort transfer carries data")

  `SEFR_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled with output free")

endmodule

bind sync_escaped_frame_receiver sefr_checker u_sefr_checker (.*);

>>> dv/testbench.sv
// Self-checking testbench for sync_escaped_frame_receiver: directed and random byte streams,
// random idle and stall bursts, and an in-bench deframing predictor checked transfer by transfer.
// Depends on sefr_pkg and the sync_escaped_frame_receiver RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 6;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_payload_byte;
  logic       out_first_of_frame;
  logic       out_last_of_frame;
  logic       out_frame_aborted;

  logic [7:0]              rx_stream[$];
  sefr_pkg::frame_result_t frame_bytes_due[$];

  logic [7:0] sync_q;
  logic [1:0] phase_q;
  logic       esc_q;
  logic [7:0] len_q;
  logic [7:0] rcv_q;

  int idle_pct = 0;
  bit quiet = 1'b0;
  int send_gap = 0;
  int stall_left = 0;
  int err_count = 0;
  int quiet_cycles = 0;

  sync_escaped_frame_receiver dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_payload_byte   (out_payload_byte),
    .out_first_of_frame (out_first_of_frame),
    .out_last_of_frame  (out_last_of_frame),
    .out_frame_aborted  (out_frame_aborted)
  );

  always #4 clk = ~clk;

  function automatic void take_length(input logic [7:0] len);
    len_q = len;
    rcv_q = 8'd0;
    if (len == 8'd0 || int'(len) > int'(sefr_pkg::MAX_PAYLOAD)) phase_q = sefr_pkg::PH_HUNT;
    else phase_q = sefr_pkg::PH_DATA;
  endfunction

  function automatic sefr_pkg::frame_result_t deframe_byte(input logic [7:0] c);
    sefr_pkg::frame_result_t r;
    logic was_open;
    r = '0;
    if (c == sync_q) begin
      if (phase_q == sefr_pkg::PH_HUNT) begin
        phase_q = sefr_pkg::PH_LEN;
        esc_q = 1'b0;
        return r;
      end
      if (esc_q) begin
        esc_q = 1'b0;
      end else begin
        esc_q = 1'b1;
        return r;
      end
    end else if (esc_q) begin
      was_open = (phase_q == sefr_pkg::PH_DATA);
      esc_q = 1'b0;
      take_length(c);
      r.emit = was_open;
      r.frame_aborted = was_open;
      return r;
    end
    if (phase_q == sefr_pkg::PH_LEN) begin
      take_length(c);
      return r;
    end
    if (phase_q == sefr_pkg::PH_DATA) begin
      r.emit = 1'b1;
      r.payload_byte = c;
      r.first_of_frame = (rcv_q == 8'd0);
      rcv_q = rcv_q + 8'd1;
      r.last_of_frame = (rcv_q == len_q);
      if (r.last_of_frame) phase_q = sefr_pkg::PH_HUNT;
      return r;
    end
    phase_q = sefr_pkg::PH_HUNT;
    return r;
  endfunction

  always @(posedge clk) begin : drive
    logic                    take;
    logic                    nxt_valid;
    logic [7:0]              nxt_byte;
    sefr_pkg::frame_result_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      take = in_valid && !in_stall;
      nxt_valid = in_valid;
      nxt_byte = in_rx_byte;
      if (take) begin
        r = deframe_byte(in_rx_byte);
        if (r.emit) frame_bytes_due.push_back(r);
      end
      if (take || !in_valid) begin
        nxt_valid = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (rx_stream.size() != 0) begin
          if (!quiet && $urandom_range(99) < idle_pct) begin
            send_gap = $urandom_range(1, 10) - 1;
          end else begin
            nxt_valid = 1'b1;
            nxt_byte = rx_stream.pop_front();
          end
        end
      end
      in_valid <= nxt_valid;
      in_rx_byte <= nxt_byte;
    end
  end

  always @(posedge clk) begin : watch_results
    sefr_pkg::frame_result_t due;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (frame_bytes_due.size() == 0) begin
          $error("unexpected transfer: payload_byte %0h aborted %0b",
                 out_payload_byte, out_frame_aborted);
          err_count++;
        end else begin
          due = frame_bytes_due.pop_front();
          if (out_payload_byte !== due.payload_byte) begin
            $error("payload_byte: expected %0h, actual %0h", due.payload_byte, out_payload_byte);
            err_count++;
          end
          if (out_first_of_frame !== due.first_of_frame) begin
            $error("first_of_frame: expected %0b, actual %0b",
                   due.first_of_frame, out_first_of_frame);
            err_count++;
          end
          if (out_last_of_frame !== due.last_of_frame) begin
            $error("last_of_frame: expected %0b, actual %0b",
                   due.last_of_frame, out_last_of_frame);
            err_count++;
          end
          if (out_frame_aborted !== due.frame_aborted) begin
            $error("frame_aborted: expected %0b, actual %0b",
                   due.frame_aborted, out_frame_aborted);
            err_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(99) < idle_pct) begin
        stall_left = $urandom_range(1, 10) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  task automatic push_coded(input logic [7:0] s, input logic [7:0] b);
    if (b == s) rx_stream.push_back(s);
    rx_stream.push_back(b);
  endtask

  task automatic push_frame(input logic [7:0] s, input int len, input int cnt);
    logic [7:0] d;
    rx_stream.push_back(s);
    push_coded(s, len[7:0]);
    repeat (cnt) begin
      d = ($urandom_range(7) == 0) ? s : 8'($urandom_range(255));
      push_coded(s, d);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    while (rx_stream.size() != 0 || in_valid || frame_bytes_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_sync(input logic [7:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    sync_q = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_phase(input logic [7:0] s, input int pct, input bit long_frame);
    int kind;
    int len;
    write_sync(s);
    idle_pct = pct;
    if (long_frame) push_frame(s, 255, 255);
    while (rx_stream.size() < 320) begin
      kind = $urandom_range(99);
      len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      if (kind < 70) begin
        push_frame(s, len, len);
      end else if (kind < 80) begin
        push_frame(s, len, $urandom_range(len - 1));
      end else if (kind < 87) begin
        rx_stream.push_back(s);
        push_frame(s, len, len);
      end else if (kind < 93) begin
        rx_stream.push_back(s);
        push_coded(s, 8'h00);
      end else begin
        repeat ($urandom_range(1, 5)) rx_stream.push_back(8'($urandom_range(255)));
      end
    end
    settle();
  endtask

  initial begin
    sync_q = sefr_pkg::SYNC_RESET;
    phase_q = sefr_pkg::PH_HUNT;
    esc_q = 1'b0;
    len_q = 8'd0;
    rcv_q = 8'd0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    idle_pct = 10;
    rx_stream = '{8'h00, 8'hFF,
                  8'h7E, 8'h02, 8'h00, 8'hFF,
                  8'h7E, 8'h03, 8'h7E, 8'h7E, 8'h11, 8'h22,
                  8'h7E, 8'h7E, 8'h01, 8'h33,
                  8'h7E, 8'h00,
                  8'h7E, 8'h04, 8'hAA, 8'h7E, 8'h02, 8'hBB, 8'hCC};
    settle();
    write_sync(8'h02);
    rx_stream = '{8'h02, 8'h02, 8'h02, 8'h02, 8'h02, 8'h55};
    settle();

    random_phase(8'h00, 20, 1'b0);
    random_phase(8'hFF, 8, 1'b1);
    random_phase(8'($urandom_range(255)), 0, 1'b0);
    random_phase(8'($urandom_range(255)), 30, 1'b0);
    random_phase(sefr_pkg::SYNC_RESET, 12, 1'b0);
    quiet = 1'b1;
    random_phase(8'($urandom_range(255)), 0, 1'b0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && frame_bytes_due.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
